[hw/rtl/ctp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_pkg: shared definitions of the cue timestamp parser
// Field widths, status codes, time constants and the finished-token record
// that the byte parser hands to the result pipeline.
// ----------------------------------------------------------------------------
package ctp_pkg;

    localparam int FIELD_BITS  = 32;
    localparam int MILLIS_BITS = 64;
    localparam int STATUS_BITS = 2;

    localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_MALFORMED = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_BAD       = 2'd2;

    localparam int HOUR_BITS   = 22;
    localparam int MINUTE_BITS = 16;
    localparam int SECOND_BITS = 10;

    localparam logic [HOUR_BITS-1:0]   MS_HOUR   = 22'd3600000;
    localparam logic [MINUTE_BITS-1:0] MS_MINUTE = 16'd60000;
    localparam logic [SECOND_BITS-1:0] MS_SECOND = 10'd1000;

    localparam logic [FIELD_BITS-1:0] FIELD_MAX      = '1;
    localparam logic [FIELD_BITS-1:0] SIXTY_LIMIT    = FIELD_BITS'(59);
    localparam logic [FIELD_BITS-1:0] FRACTION_LIMIT = FIELD_BITS'(999);

    typedef struct packed {
        logic                  fatal;
        logic                  malformed;
        logic [FIELD_BITS-1:0] hours;
        logic [FIELD_BITS-1:0] minutes;
        logic [FIELD_BITS-1:0] seconds;
        logic [FIELD_BITS-1:0] fraction;
    } ctp_snap_t;

endpackage
`default_nettype wire

[hw/rtl/ctp_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_parser: per-byte parse state machine
// Updates phase, digit counts and field accumulators once per accepted word,
// and presents the finished token record when the last word is taken.
// ----------------------------------------------------------------------------
module ctp_parser
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        take,
    input  wire logic [7:0]                  text_byte,
    input  wire logic                        token_end,
    output logic                             snap_valid,
    output ctp_pkg::ctp_snap_t               snap
);

    localparam int FB = ctp_pkg::FIELD_BITS;

    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    typedef enum logic [3:0] {
        PH_START,
        PH_F0,
        PH_F1_FIRST,
        PH_F1,
        PH_F2_FIRST,
        PH_F2,
        PH_F3_FIRST,
        PH_F3,
        PH_DONE,
        PH_FATAL
    } phase_t;

    typedef struct packed {
        phase_t        ph;
        logic [FB-1:0] h;
        logic [FB-1:0] m;
        logic [FB-1:0] s;
        logic [FB-1:0] f;
        logic [3:0]    dc;
        logic          hp;
        logic          mal;
        logic          fat;
    } pstate_t;

    localparam pstate_t STATE_RESET = '{
        ph:  PH_START,
        h:   '0,
        m:   '0,
        s:   '0,
        f:   '0,
        dc:  4'd0,
        hp:  1'b0,
        mal: 1'b0,
        fat: 1'b0
    };

    pstate_t state_reg;
    pstate_t state_a;
    pstate_t state_b;

    // Appends one decimal digit, saturating at the field maximum.
    function automatic logic [FB-1:0] add_digit(logic [FB-1:0] v, logic [3:0] d);
        logic [FB+3:0] wide;
        wide = ({4'd0, v} << 3) + ({4'd0, v} << 1) + {{FB{1'b0}}, d};
        if (wide > {4'd0, ctp_pkg::FIELD_MAX})
        begin
            add_digit = ctp_pkg::FIELD_MAX;
        end
        else
        begin
            add_digit = wide[FB-1:0];
        end
    endfunction

    function automatic logic [3:0] bump_count(logic [3:0] dc);
        bump_count = (dc == 4'hF) ? dc : dc + 4'd1;
    endfunction

    function automatic pstate_t go_fatal(pstate_t st_in);
        pstate_t st;
        st     = st_in;
        st.fat = 1'b1;
        st.ph  = PH_FATAL;
        go_fatal = st;
    endfunction

    function automatic pstate_t after_seconds(pstate_t st_in, logic [7:0] c);
        pstate_t st;
        st = st_in;
        if (c == CHAR_DOT)
        begin
            st.ph = PH_F3_FIRST;
        end
        else
        begin
            st = go_fatal(st);
        end
        after_seconds = st;
    endfunction

    // Without hours the fields read so far are minutes and seconds, so they
    // move down one place before the seconds separator is checked.
    function automatic pstate_t after_minutes(pstate_t st_in, logic [7:0] c);
        pstate_t st;
        st = st_in;
        if (st.hp || (c == CHAR_COLON))
        begin
            if (c == CHAR_COLON)
            begin
                st.ph = PH_F2_FIRST;
            end
            else
            begin
                st = go_fatal(st);
            end
        end
        else
        begin
            st.s = st.m;
            st.m = st.h;
            st.h = '0;
            st   = after_seconds(st, c);
        end
        after_minutes = st;
    endfunction

    function automatic pstate_t take_byte(pstate_t st_in, logic [7:0] c);
        pstate_t       st;
        logic          dg;
        logic [FB-1:0] dv;
        st = st_in;
        dg = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
        dv = {{(FB-4){1'b0}}, (dg ? c[3:0] : 4'd0)};
        unique case (st.ph)
            PH_START:
            begin
                if (dg)
                begin
                    st.h  = dv;
                    st.dc = 4'd1;
                    st.ph = PH_F0;
                end
                else
                begin
                    st = go_fatal(st);
                end
            end
            PH_F0:
            begin
                if (dg)
                begin
                    st.h  = add_digit(st.h, dv[3:0]);
                    st.dc = bump_count(st.dc);
                end
                else
                begin
                    st.hp = (st.dc != 4'd2) || (st.h > ctp_pkg::SIXTY_LIMIT);
                    if (c != CHAR_COLON)
                    begin
                        st.mal = 1'b1;
                    end
                    st.ph = PH_F1_FIRST;
                end
            end
            PH_F1_FIRST:
            begin
                if (dg)
                begin
                    st.m  = dv;
                    st.dc = 4'd1;
                    st.ph = PH_F1;
                end
                else
                begin
                    st.mal = 1'b1;
                    st.m   = '0;
                    st     = after_minutes(st, c);
                end
            end
            PH_F1:
            begin
                if (dg)
                begin
                    st.m  = add_digit(st.m, dv[3:0]);
                    st.dc = bump_count(st.dc);
                end
                else
                begin
                    if (st.dc != 4'd2)
                    begin
                        st.mal = 1'b1;
                    end
                    st = after_minutes(st, c);
                end
            end
            PH_F2_FIRST:
            begin
                if (dg)
                begin
                    st.s  = dv;
                    st.dc = 4'd1;
                    st.ph = PH_F2;
                end
                else
                begin
                    st.mal = 1'b1;
                    st.s   = '0;
                    st     = after_seconds(st, c);
                end
            end
            PH_F2:
            begin
                if (dg)
                begin
                    st.s  = add_digit(st.s, dv[3:0]);
                    st.dc = bump_count(st.dc);
                end
                else
                begin
                    if (st.dc != 4'd2)
                    begin
                        st.mal = 1'b1;
                    end
                    st = after_seconds(st, c);
                end
            end
            PH_F3_FIRST:
            begin
                if (dg)
                begin
                    st.f  = dv;
                    st.dc = 4'd1;
                    st.ph = PH_F3;
                end
                else
                begin
                    st = go_fatal(st);
                end
            end
            PH_F3:
            begin
                if (dg)
                begin
                    st.f  = add_digit(st.f, dv[3:0]);
                    st.dc = bump_count(st.dc);
                end
                else
                begin
                    if (st.dc != 4'd3)
                    begin
                        st.mal = 1'b1;
                    end
                    st.ph = PH_DONE;
                end
            end
            default:
            begin
                st = st_in;
            end
        endcase
        take_byte = st;
    endfunction

    // The text ends cleanly only inside or after the fraction digits.
    function automatic pstate_t end_text(pstate_t st_in);
        pstate_t st;
        st = st_in;
        if (st.ph == PH_F3)
        begin
            if (st.dc != 4'd3)
            begin
                st.mal = 1'b1;
            end
            st.ph = PH_DONE;
        end
        else if ((st.ph != PH_DONE) && (st.ph != PH_FATAL))
        begin
            st = go_fatal(st);
        end
        end_text = st;
    endfunction

    always_comb
    begin
        state_a = state_reg;
        if ((state_reg.ph != PH_DONE) && (state_reg.ph != PH_FATAL))
        begin
            if (text_byte == CHAR_NUL)
            begin
                state_a = end_text(state_reg);
            end
            else
            begin
                state_a = take_byte(state_reg, text_byte);
            end
        end
        state_b = token_end ? end_text(state_a) : state_a;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_RESET;
        end
        else if (take)
        begin
            state_reg <= token_end ? STATE_RESET : state_b;
        end
    end

    assign snap_valid     = take && token_end;
    assign snap.fatal     = state_b.fat;
    assign snap.malformed = state_b.mal;
    assign snap.hours     = state_b.h;
    assign snap.minutes   = state_b.m;
    assign snap.seconds   = state_b.s;
    assign snap.fraction  = state_b.f;

    a_fatal_phase: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.fat == (state_reg.ph == PH_FATAL))
        else $error("fatal flag and fatal phase disagree");

    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        take && token_end |=> (state_reg.ph == PH_START) && !state_reg.mal
            && !state_reg.hp)
        else $error("parser did not restart after the last word");

    a_fraction_digits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.ph == PH_F3) |-> (state_reg.dc != 4'd0))
        else $error("fraction phase without a digit");

endmodule
`default_nettype wire

[hw/rtl/ctp_finish.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctp_finish: result pipeline
// Turns a finished token record into milliseconds and status over four
// stalling stages: capture, scale, partial sums, final sum.
// ----------------------------------------------------------------------------
module ctp_finish
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 push,
    input  wire ctp_pkg::ctp_snap_t                   snap,
    output logic                                      full,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [ctp_pkg::MILLIS_BITS-1:0]           millis,
    output logic [ctp_pkg::STATUS_BITS-1:0]           parse_status
);

    localparam int FB = ctp_pkg::FIELD_BITS;
    localparam int MB = ctp_pkg::MILLIS_BITS;
    localparam int HW = FB + ctp_pkg::HOUR_BITS;
    localparam int MW = FB + ctp_pkg::MINUTE_BITS;
    localparam int SW = FB + ctp_pkg::SECOND_BITS;

    logic v0_reg, v1_reg, v2_reg, v3_reg;
    logic adv0, adv1, adv2, adv3;

    ctp_pkg::ctp_snap_t snap_reg;

    logic [HW-1:0] ph_reg, ph_next;
    logic [MW-1:0] pm_reg, pm_next;
    logic [SW-1:0] ps_reg, ps_next;
    logic [FB-1:0] f1_reg;
    logic          bad1_reg, mal1_reg, mal1_next;

    logic [MB-1:0] sa_reg, sa_next, sb_reg, sb_next;
    logic          bad2_reg, mal2_reg;

    logic [MB-1:0]                   ms_reg, ms_next;
    logic [ctp_pkg::STATUS_BITS-1:0] st_reg, st_next;

    assign adv3 = !v3_reg || !out_stall;
    assign adv2 = !v2_reg || adv3;
    assign adv1 = !v1_reg || adv2;
    assign adv0 = !v0_reg || adv1;
    assign full = !adv0;

    // Carries between fields leave the total unchanged; they only mark the
    // token as malformed, which a plain range check on minutes, seconds and fraction detects.
    assign ph_next   = HW'(snap_reg.hours) * HW'(ctp_pkg::MS_HOUR);
    assign pm_next   = MW'(snap_reg.minutes) * MW'(ctp_pkg::MS_MINUTE);
    assign ps_next   = SW'(snap_reg.seconds) * SW'(ctp_pkg::MS_SECOND);
    assign mal1_next = snap_reg.malformed
                       || (snap_reg.fraction > ctp_pkg::FRACTION_LIMIT)
                       || (snap_reg.seconds > ctp_pkg::SIXTY_LIMIT)
                       || (snap_reg.minutes > ctp_pkg::SIXTY_LIMIT);

    assign sa_next = MB'(ph_reg) + MB'(pm_reg);
    assign sb_next = MB'(ps_reg) + MB'(f1_reg);

    always_comb
    begin
        if (bad2_reg)
        begin
            ms_next = '1;
            st_next = ctp_pkg::STATUS_BAD;
        end
        else
        begin
            ms_next = sa_reg + sb_reg;
            st_next = mal2_reg ? ctp_pkg::STATUS_MALFORMED : ctp_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (adv0)
            begin
                v0_reg <= push;
            end
            if (adv1)
            begin
                v1_reg <= v0_reg;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
            if (adv3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv0 && push)
        begin
            snap_reg <= snap;
        end
        if (adv1)
        begin
            ph_reg   <= ph_next;
            pm_reg   <= pm_next;
            ps_reg   <= ps_next;
            f1_reg   <= snap_reg.fraction;
            bad1_reg <= snap_reg.fatal;
            mal1_reg <= mal1_next;
        end
        if (adv2)
        begin
            sa_reg   <= sa_next;
            sb_reg   <= sb_next;
            bad2_reg <= bad1_reg;
            mal2_reg <= mal1_reg;
        end
        if (adv3)
        begin
            ms_reg <= ms_next;
            st_reg <= st_next;
        end
    end

    assign out_valid    = v3_reg;
    assign millis       = ms_reg;
    assign parse_status = st_reg;

    a_full_only_when_packed: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> v0_reg && v1_reg && v2_reg && v3_reg && out_stall)
        else $error("input held off while the pipeline has room");

    a_bad_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (parse_status == ctp_pkg::STATUS_BAD) |-> (&millis))
        else $error("bad-shape word without an all-ones value");

endmodule
`default_nettype wire

[hw/rtl/cue_timestamp_parser.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// cue_timestamp_parser: subtitle timestamp text to milliseconds
// Parses [h..]:mm:ss.fff or mm:ss.fff one byte per word and gives one result
// word, milliseconds and status, for each token.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake              | Word
//  --------+------------------------+----------------------------------
//  in      | in_valid / in_stall    | text_byte[7:0], token_end
//  out     | out_valid / out_stall  | millis[63:0], parse_status[1:0]
//
// One text byte is taken per cycle while in_stall is low, tokens back to back with no gap.
// The result of a token passes through four registered stages after its
// last byte is taken: capture, constant multiplies, partial sums and final sum.
// Reset returns the parser to the start of a token and empties the pipeline.
// out_stall holds the four result stages; in_stall rises only when all four
// hold a result.
//
module cue_timestamp_parser
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_stall,
    input  wire logic [7:0]                           text_byte,
    input  wire logic                                 token_end,
    output logic                                      out_valid,
    input  wire logic                                 out_stall,
    output logic [ctp_pkg::MILLIS_BITS-1:0]           millis,
    output logic [ctp_pkg::STATUS_BITS-1:0]           parse_status
);

    logic               take;
    logic               fin_full;
    logic               snap_valid;
    ctp_pkg::ctp_snap_t snap;

    assign in_stall = fin_full;
    assign take     = in_valid && !fin_full;

    ctp_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .text_byte  (text_byte),
        .token_end  (token_end),
        .snap_valid (snap_valid),
        .snap       (snap)
    );

    ctp_finish u_finish
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (snap_valid),
        .snap         (snap),
        .full         (fin_full),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .millis       (millis),
        .parse_status (parse_status)
    );

endmodule
`default_nettype wire
